### sv/tilt_compensated_compass_heading_defines.svh
// Assertion macros for the compass heading block.
// No dependencies.
`ifndef TILT_COMPENSATED_COMPASS_HEADING_DEFINES_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_DEFINES_SVH
// implication checked on every clock, quiet in reset
`define TCCH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define TCCH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### sv/tcch_pkg.sv
// Shared types and constants for the compass heading block.
// No dependencies.
package tcch_pkg;
	localparam int TableLen = 24;
	localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;
	localparam logic [14:0] Deg90 = 15'd5760;
	localparam logic [14:0] Deg180 = 15'd11520;
	localparam logic [14:0] Deg270 = 15'd17280;
	localparam logic [14:0] Deg360 = 15'd23040;

	typedef enum logic [1:0] {
		REG_X_SCALE  = 2'd0,
		REG_Y_SCALE  = 2'd1,
		REG_X_OFFSET = 2'd2,
		REG_Y_OFFSET = 2'd3
	} reg_idx_t;

	function automatic logic signed [31:0] atan_entry(input int i);
		logic signed [31:0] t [TableLen];
		t = '{32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
			32'sd15000234, 32'sd7507429, 32'sd3754631, 32'sd1877430,
			32'sd938729, 32'sd469366, 32'sd234683, 32'sd117342,
			32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334,
			32'sd3667, 32'sd1833, 32'sd917, 32'sd458,
			32'sd229, 32'sd115, 32'sd57, 32'sd29};
		return t[i];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) return 16'sh7fff;
		if (v < -64'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction
endpackage

### sv/tcch_rotate.sv
// Rotation-mode CORDIC pipeline: sin and cos of an angle in 1/64 degree, Q15.
// Uses tcch_pkg. One stage per iteration, stalls with the shared enable.
module tcch_rotate #(
	parameter int STEPS = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [14:0]  angle,
	output logic signed [16:0]  sin_q15,
	output logic signed [16:0]  cos_q15
);
	logic signed [33:0] x_s [1:STEPS];
	logic signed [33:0] y_s [1:STEPS];
	logic signed [33:0] z_s [1:STEPS];
	logic               flip_s [1:STEPS];
	logic signed [15:0] a_red;
	logic               flip0;
	logic signed [33:0] x0, y0, z0;
	logic signed [33:0] xr, yr;

	always_comb begin
		a_red = {angle[14], angle};
		flip0 = 1'b0;
		if (angle > 15'sd5760) begin
			a_red = {angle[14], angle} - 16'sd11520;
			flip0 = 1'b1;
		end else if (angle < -15'sd5760) begin
			a_red = {angle[14], angle} + 16'sd11520;
			flip0 = 1'b1;
		end
		x0 = 34'(tcch_pkg::CordicGainQ30);
		y0 = '0;
		z0 = 34'(a_red) <<< 16;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_it
		logic signed [33:0] xi, yi, zi;
		logic               fi;
		if (i == 0) begin : g_in
			assign xi = x0;
			assign yi = y0;
			assign zi = z0;
			assign fi = flip0;
		end else begin : g_mid
			assign xi = x_s[i];
			assign yi = y_s[i];
			assign zi = z_s[i];
			assign fi = flip_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= fi;
				if (zi >= 0) begin
					x_s[i+1] <= xi - (yi >>> i);
					y_s[i+1] <= yi + (xi >>> i);
					z_s[i+1] <= zi - 34'(tcch_pkg::atan_entry(i));
				end else begin
					x_s[i+1] <= xi + (yi >>> i);
					y_s[i+1] <= yi - (xi >>> i);
					z_s[i+1] <= zi + 34'(tcch_pkg::atan_entry(i));
				end
			end
		end
	end

	always_comb begin
		xr = (x_s[STEPS] + 34'sd16384) >>> 15;
		yr = (y_s[STEPS] + 34'sd16384) >>> 15;
		cos_q15 = flip_s[STEPS] ? -xr[16:0] : xr[16:0];
		sin_q15 = flip_s[STEPS] ? -yr[16:0] : yr[16:0];
	end
endmodule

### sv/tcch_vector.sv
// Vectoring-mode CORDIC pipeline: atan(y/x) in 1/64 degree for x > 0.
// Uses tcch_pkg. One stage per iteration with the shared enable.
module tcch_vector #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [16:0] vx,
	input  logic signed [16:0] vy,
	output logic signed [15:0] angle
);
	logic signed [35:0] x_s [1:STEPS];
	logic signed [35:0] y_s [1:STEPS];
	logic signed [35:0] z_s [1:STEPS];
	logic signed [35:0] x0, y0, z0;
	logic signed [35:0] zr;

	always_comb begin
		x0 = 36'(vx) <<< 16;
		y0 = 36'(vy) <<< 16;
		z0 = '0;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_it
		logic signed [35:0] xi, yi, zi;
		if (i == 0) begin : g_in
			assign xi = x0;
			assign yi = y0;
			assign zi = z0;
		end else begin : g_mid
			assign xi = x_s[i];
			assign yi = y_s[i];
			assign zi = z_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (yi >= 0) begin
					x_s[i+1] <= xi + (yi >>> i);
					y_s[i+1] <= yi - (xi >>> i);
					z_s[i+1] <= zi + 36'(tcch_pkg::atan_entry(i));
				end else begin
					x_s[i+1] <= xi - (yi >>> i);
					y_s[i+1] <= yi + (xi >>> i);
					z_s[i+1] <= zi - 36'(tcch_pkg::atan_entry(i));
				end
			end
		end
	end

	always_comb begin
		zr = (z_s[STEPS] + 36'sd32768) >>> 16;
		angle = zr[15:0];
	end
endmodule

### sv/tilt_compensated_compass_heading.sv
// Top level of the tilt-compensated compass heading pipeline.
// Uses tcch_pkg, tcch_rotate, tcch_vector.
//  channel | dir | payload
//  s_axis  | in  | tdata: field_x, field_y, field_z, pitch_angle, roll_angle
//  m_axis  | out | tdata: heading
//  cfg     | in  | wr_en, wr_idx, wr_data: x_scale, y_scale, x_offset, y_offset
// One request per cycle unless stalled, set by the unrolled CORDICs.
// The whole pipeline advances together; it stalls only when the output holds a
// result and m_axis_tready is low, so nothing is lost or repeated.
// Reset clears valid bits and loads the register defaults.
module tilt_compensated_compass_heading #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // field_x, field_y, field_z, pitch, roll, 2'b0
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // heading, 1'b0
	input  logic        wr_en,
	input  logic [1:0]  wr_idx,
	input  logic [23:0] wr_data
);
	localparam int Depth = 2 * CORDIC_STEPS + 4;

	logic [15:0] x_scale_q, y_scale_q;
	logic signed [23:0] x_off_q, y_off_q;
	logic [Depth-1:0] vld_q;
	logic en;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[Depth-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q <= 16'd17890;
			y_scale_q <= 16'd16384;
			x_off_q <= -24'sd1817;
			y_off_q <= -24'sd7808;
		end else if (wr_en) begin
			case (tcch_pkg::reg_idx_t'(wr_idx))
				tcch_pkg::REG_X_SCALE: x_scale_q <= wr_data[15:0];
				tcch_pkg::REG_Y_SCALE: y_scale_q <= wr_data[15:0];
				tcch_pkg::REG_X_OFFSET: x_off_q <= wr_data;
				tcch_pkg::REG_Y_OFFSET: y_off_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
	end

	logic signed [15:0] fx, fy, fz;
	logic signed [14:0] pa, ra;
	assign fx = s_axis_tdata[15:0];
	assign fy = s_axis_tdata[31:16];
	assign fz = s_axis_tdata[47:32];
	assign pa = s_axis_tdata[62:48];
	assign ra = s_axis_tdata[77:63];

	// stage 1: calibration products
	logic signed [33:0] px_s1, py_s1;
	logic signed [15:0] fz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed({1'b0, x_scale_q}) * fx + (34'(x_off_q) <<< 6);
			py_s1 <= $signed({1'b0, y_scale_q}) * fy + (34'(y_off_q) <<< 6);
			fz_s1 <= fz;
		end
	end

	// stage 2: divide toward zero and saturate
	logic signed [33:0] qx, qy;
	always_comb begin
		qx = (px_s1 + (px_s1 < 0 ? 34'sd16383 : 34'sd0)) >>> 14;
		qy = (py_s1 + (py_s1 < 0 ? 34'sd16383 : 34'sd0)) >>> 14;
	end
	logic signed [15:0] cx_s2, cy_s2, fz_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s2 <= tcch_pkg::sat16(64'(qx));
			cy_s2 <= tcch_pkg::sat16(64'(qy));
			fz_s2 <= fz_s1;
		end
	end

	// delay calibrated axes to meet the CORDIC outputs
	logic signed [15:0] cx_d [CORDIC_STEPS-2];
	logic signed [15:0] cy_d [CORDIC_STEPS-2];
	logic signed [15:0] fz_d [CORDIC_STEPS-2];
	always_ff @(posedge clk) begin
		if (en) begin
			cx_d[0] <= cx_s2; cy_d[0] <= cy_s2; fz_d[0] <= fz_s2;
			for (int i = 1; i < CORDIC_STEPS - 2; i++) begin
				cx_d[i] <= cx_d[i-1]; cy_d[i] <= cy_d[i-1]; fz_d[i] <= fz_d[i-1];
			end
		end
	end

	logic signed [16:0] sp, cp, sr, cr;
	tcch_rotate #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .en(en), .angle(pa), .sin_q15(sp), .cos_q15(cp));
	tcch_rotate #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .en(en), .angle(ra), .sin_q15(sr), .cos_q15(cr));

	// stage A: trig products
	logic signed [33:0] srsp_a, crsp_a;
	logic signed [16:0] cp_a, sr_a, cr_a;
	logic signed [15:0] cx_a, cy_a, fz_a;
	always_ff @(posedge clk) begin
		if (en) begin
			srsp_a <= sr * sp;
			crsp_a <= cr * sp;
			cp_a <= cp; sr_a <= sr; cr_a <= cr;
			cx_a <= cx_d[CORDIC_STEPS-3];
			cy_a <= cy_d[CORDIC_STEPS-3];
			fz_a <= fz_d[CORDIC_STEPS-3];
		end
	end

	// stage B: terms
	logic signed [48:0] t1_b, t2_b, t3_b;
	logic signed [33:0] u1_b, u2_b;
	always_ff @(posedge clk) begin
		if (en) begin
			t1_b <= 49'(cx_a * cp_a) <<< 15;
			t2_b <= 49'(cy_a * srsp_a);
			t3_b <= 49'(fz_a * crsp_a);
			u1_b <= 34'(cy_a * cr_a);
			u2_b <= 34'(fz_a * sr_a);
		end
	end

	// stage C: sums, truncate, saturate
	logic signed [49:0] sx;
	logic signed [34:0] sy;
	logic signed [49:0] dx;
	logic signed [34:0] dy;
	always_comb begin
		sx = 50'(t1_b) + 50'(t2_b) - 50'(t3_b);
		sy = 35'(u1_b) + 35'(u2_b);
		dx = (sx + (sx < 0 ? 50'sd1073741823 : 50'sd0)) >>> 30;
		dy = (sy + (sy < 0 ? 35'sd32767 : 35'sd0)) >>> 15;
	end
	logic signed [15:0] nx_c, ny_c;
	always_ff @(posedge clk) begin
		if (en) begin
			nx_c <= tcch_pkg::sat16(64'(dx));
			ny_c <= tcch_pkg::sat16(64'(dy));
		end
	end

	// vector CORDIC on the quadrant-folded vector
	logic signed [16:0] vx, vy;
	always_comb begin
		if (nx_c < 0) begin
			vx = -17'(nx_c); vy = -17'(ny_c);
		end else begin
			vx = 17'(nx_c); vy = 17'(ny_c);
		end
	end
	logic signed [15:0] t_ang;
	tcch_vector #(.STEPS(CORDIC_STEPS)) u_atan (
		.clk(clk), .en(en), .vx(vx), .vy(vy), .angle(t_ang));

	logic signed [15:0] nx_d [CORDIC_STEPS];
	logic signed [15:0] ny_d [CORDIC_STEPS];
	always_ff @(posedge clk) begin
		if (en) begin
			nx_d[0] <= nx_c; ny_d[0] <= ny_c;
			for (int i = 1; i < CORDIC_STEPS; i++) begin
				nx_d[i] <= nx_d[i-1]; ny_d[i] <= ny_d[i-1];
			end
		end
	end

	logic signed [16:0] hd;
	logic signed [15:0] nxe, nye;
	always_comb begin
		nxe = nx_d[CORDIC_STEPS-1];
		nye = ny_d[CORDIC_STEPS-1];
		if (nxe == 0 && nye < 0) hd = 17'(tcch_pkg::Deg90);
		else if (nxe == 0 && nye > 0) hd = 17'(tcch_pkg::Deg270);
		else if (nxe < 0) hd = 17'(tcch_pkg::Deg180) - 17'(t_ang);
		else if (nxe > 0 && nye < 0) hd = -17'(t_ang);
		else if (nxe > 0 && nye > 0) hd = 17'(tcch_pkg::Deg360) - 17'(t_ang);
		else hd = '0;
	end

	logic [14:0] hd_q;
	always_ff @(posedge clk) begin
		if (en) begin
			if (hd < 0) hd_q <= '0;
			else if (hd > 17'(tcch_pkg::Deg360)) hd_q <= tcch_pkg::Deg360;
			else hd_q <= hd[14:0];
		end
	end

	assign m_axis_tdata = {1'b0, hd_q};
endmodule

### sv/tcch_checker.sv
// Port-level checker for the compass heading block, with its bind.
// Uses tilt_compensated_compass_heading_defines.svh.
`include "tilt_compensated_compass_heading_defines.svh"
module tcch_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);
	`TCCH_ASSERT_IMP(a_range, m_axis_tvalid, m_axis_tdata <= 16'd23040)
	`TCCH_ASSERT_IMP(a_ready, !m_axis_tvalid || m_axis_tready, s_axis_tready)
	`TCCH_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`TCCH_ASSERT_NXT(a_vhold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind tilt_compensated_compass_heading tcch_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata));

### sim/tilt_compensated_compass_heading_tb.sv
// Self-checking bench for tilt_compensated_compass_heading: random and directed axes
// with pitch/roll, register changes between phases, heading checked in order.
// Depends on tcch_pkg and the block's RTL.
module tilt_compensated_compass_heading_tb;
	localparam int Steps = 16;
	localparam int Latency = 2 * Steps + 4;
	localparam int StallLimit = 5000;

	typedef struct {
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic signed [15:0] fz;
		logic signed [14:0] pitch;
		logic signed [14:0] roll;
	} axes_t;

	class heading_board;
		longint x_gain, y_gain, x_bias, y_bias;
		logic [14:0] headings_due[$];
		int errors;
		int mismatches;
		longint atan_deg[Steps];

		function new();
			atan_deg = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
				3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335,
				14668, 7334};
			x_gain = 17890;
			y_gain = 16384;
			x_bias = -1817;
			y_bias = -7808;
		endfunction

		function void set_reg(tcch_pkg::reg_idx_t idx, logic [23:0] val);
			case (idx)
				tcch_pkg::REG_X_SCALE: x_gain = longint'(val[15:0]);
				tcch_pkg::REG_Y_SCALE: y_gain = longint'(val[15:0]);
				tcch_pkg::REG_X_OFFSET: x_bias = longint'($signed(val));
				tcch_pkg::REG_Y_OFFSET: y_bias = longint'($signed(val));
				default: ;
			endcase
		endfunction

		function longint clamp16(longint v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return v;
		endfunction

		function void rotate(longint ang, output longint sn, output longint cs);
			longint x, y, z, dx, dy;
			bit flip;
			flip = 0;
			x = 652032874;
			y = 0;
			if (ang > 5760) begin
				ang -= 11520;
				flip = 1;
			end else if (ang < -5760) begin
				ang += 11520;
				flip = 1;
			end
			z = ang * 65536;
			for (int i = 0; i < Steps; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_deg[i];
				end else begin
					x += dx; y -= dy; z += atan_deg[i];
				end
			end
			cs = (x + 16384) >>> 15;
			sn = (y + 16384) >>> 15;
			if (flip) begin
				cs = -cs;
				sn = -sn;
			end
		endfunction

		function longint arctan(longint xi, longint yi);
			longint x, y, z, dx, dy;
			x = xi * 65536;
			y = yi * 65536;
			z = 0;
			for (int i = 0; i < Steps; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += atan_deg[i];
				end else begin
					x -= dx; y += dy; z -= atan_deg[i];
				end
			end
			return (z + 32768) >>> 16;
		endfunction

		function void note_request(axes_t a);
			longint fx, fy, fz, cx, cy, sp, cp, sr, cr, nx, ny, hd;
			fx = a.fx;
			fy = a.fy;
			fz = a.fz;
			cx = clamp16((x_gain * fx + x_bias * 64) / 16384);
			cy = clamp16((y_gain * fy + y_bias * 64) / 16384);
			rotate(longint'(a.pitch), sp, cp);
			rotate(longint'(a.roll), sr, cr);
			nx = clamp16((cx * cp * 32768 + cy * (sr * sp) - fz * (cr * sp)) / 1073741824);
			ny = clamp16((cy * cr + fz * sr) / 32768);
			if (nx == 0 && ny < 0) hd = 5760;
			else if (nx == 0 && ny > 0) hd = 17280;
			else if (nx < 0) hd = 11520 - arctan(-nx, -ny);
			else if (nx > 0 && ny < 0) hd = -arctan(nx, ny);
			else if (nx > 0 && ny > 0) hd = 23040 - arctan(nx, ny);
			else hd = 0;
			if (hd < 0) hd = 0;
			if (hd > 23040) hd = 23040;
			headings_due.push_back(hd[14:0]);
		endfunction

		function void check_result(logic [15:0] data);
			logic [14:0] want;
			if (headings_due.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected heading %0d", data[14:0]);
				return;
			end
			want = headings_due.pop_front();
			if (data[14:0] !== want) begin
				errors++;
				if (mismatches++ < 10)
					$display("heading mismatch: expected %0d got %0d", want, data[14:0]);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic wr_en = 0;
	logic [1:0] wr_idx = '0;
	logic [23:0] wr_data = '0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int quiet_cycles = 0;
	heading_board board = new();

	tilt_compensated_compass_heading #(.CORDIC_STEPS(Steps)) dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_axes(axes_t a);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {2'b00, a.roll, a.pitch, a.fz, a.fy, a.fx};
		do @(posedge clk); while (!s_axis_tready);
		board.note_request(a);
		@(negedge clk);
	endtask

	task automatic write_reg(tcch_pkg::reg_idx_t idx, logic [23:0] val);
		s_axis_tvalid <= 0;
		@(negedge clk);
		while (board.headings_due.size() != 0) @(negedge clk);
		repeat (Latency + 10) @(negedge clk);
		wr_en <= 1;
		wr_idx <= idx;
		wr_data <= val;
		board.set_reg(idx, val);
		@(negedge clk);
		wr_en <= 0;
	endtask

	task automatic send_fields(int fx, int fy, int fz, int p, int r);
		axes_t a;
		a.fx = 16'(fx);
		a.fy = 16'(fy);
		a.fz = 16'(fz);
		a.pitch = 15'(p);
		a.roll = 15'(r);
		send_axes(a);
	endtask

	function automatic axes_t random_axes();
		axes_t a;
		a.fx = 16'($urandom);
		a.fy = 16'($urandom);
		a.fz = ($urandom_range(3) == 0) ? 16'($urandom) :
			16'($signed($urandom_range(2000)) - 1000);
		if ($urandom_range(4) == 0) begin
			a.pitch = 15'($urandom);
			a.roll = 15'($urandom);
		end else begin
			a.pitch = 15'($signed($urandom_range(23040)) - 11520);
			a.roll = 15'($signed($urandom_range(23040)) - 11520);
		end
		return a;
	endfunction

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// reset calibration values
		send_fields(0, 0, 0, 0, 0);
		send_fields(32767, -32768, 1000, 0, 0);
		send_fields(-32768, 32767, -32768, 11520, -11520);

		// identity calibration, quadrant and tilt corner cases
		write_reg(tcch_pkg::REG_X_SCALE, 24'd16384);
		write_reg(tcch_pkg::REG_Y_SCALE, 24'd16384);
		write_reg(tcch_pkg::REG_X_OFFSET, 24'd0);
		write_reg(tcch_pkg::REG_Y_OFFSET, 24'd0);
		send_fields(0, 0, 0, 0, 0);
		send_fields(100, 0, 0, 0, 0);
		send_fields(0, -100, 0, 5760, 0);
		send_fields(0, 100, 0, 5760, 0);
		send_fields(-100, 50, 0, 0, 0);
		send_fields(100, -50, 0, 0, 0);
		send_fields(100, 50, 0, 0, 0);
		send_fields(-100, -50, 0, 0, 0);
		send_fields(32767, 32767, 32767, -5760, 5760);
		send_fields(-32768, -32768, -32768, 5761, -5761);
		send_fields(1000, 300, -500, 16383, -16384);
		send_fields(-1000, 300, 500, -16384, 16383);
		send_fields(500, -500, 200, 11520, 11520);
		send_fields(-300, 700, -32768, -11520, 3000);

		for (int blk = 0; blk < 9; blk++) begin
			if (blk == 0) begin
				tx_idle_pct = 19; rx_idle_pct = 70;
			end else if (blk == 3) begin
				tx_idle_pct = 70; rx_idle_pct = 19;
			end else if (blk == 6) begin
				tx_idle_pct = 0; rx_idle_pct = 0;
			end
			case (blk % 3)
				0: begin
					write_reg(tcch_pkg::REG_X_SCALE, 24'($urandom_range(12000, 22000)));
					write_reg(tcch_pkg::REG_Y_SCALE, 24'($urandom_range(12000, 22000)));
					write_reg(tcch_pkg::REG_X_OFFSET,
						24'($signed($urandom_range(20000)) - 10000));
					write_reg(tcch_pkg::REG_Y_OFFSET,
						24'($signed($urandom_range(20000)) - 10000));
				end
				1: begin
					write_reg(tcch_pkg::REG_X_SCALE, 24'hffffff);
					write_reg(tcch_pkg::REG_Y_SCALE, 24'h00ffff);
					write_reg(tcch_pkg::REG_X_OFFSET, 24'h7fffff);
					write_reg(tcch_pkg::REG_Y_OFFSET, 24'h800000);
				end
				default: begin
					write_reg(tcch_pkg::REG_X_SCALE, 24'd0);
					write_reg(tcch_pkg::REG_Y_SCALE, 24'($urandom));
					write_reg(tcch_pkg::REG_X_OFFSET, 24'h800000);
					write_reg(tcch_pkg::REG_Y_OFFSET, 24'($urandom));
				end
			endcase
			for (int n = 0; n < 210; n++) send_axes(random_axes());
		end
		s_axis_tvalid <= 0;

		while (board.headings_due.size() != 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
		if (board.errors == 0 && board.headings_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

### filelist.f
+incdir+sv
sv/tcch_pkg.sv
sv/tcch_rotate.sv
sv/tcch_vector.sv
sv/tilt_compensated_compass_heading.sv
sv/tcch_checker.sv
sim/tilt_compensated_compass_heading_tb.sv
